/* sv/pfb_pkg.sv */
package pfb_pkg;

  localparam int unsigned PANEL_WIDTH_DEF  = 84;
  localparam int unsigned PANEL_HEIGHT_DEF = 48;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned PAGE_W     = 3;
  localparam int unsigned ROT_W      = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ROT_W-1:0]  ROTATION_RST = 2'd0;
  localparam logic [BYTE_W-1:0] PAGE_CMD_RST = 8'd64;
  localparam logic [BYTE_W-1:0] COL_CMD_RST  = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_PULL  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION = 2'd0,
    REG_PAGE_CMD = 2'd1,
    REG_COL_CMD  = 2'd2
  } cfg_reg_e;

  typedef enum logic [ROT_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_COL   = 3'd1,
    PH_DATA  = 3'd2,
    PH_PAGE  = 3'd3,
    PH_FINAL = 3'd4
  } flush_phase_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SET_WR,
    BK_DATA_OUT
  } back_state_e;

  typedef struct packed {
    cmd_e             kind;
    logic [COL_W-1:0] px;
    logic [ROW_W-1:0] py;
    logic             ink;
  } op_t;

  typedef struct packed {
    logic [ROW_W-1:0] bottom;
    logic [ROW_W-1:0] top;
    logic [COL_W-1:0] right;
    logic [COL_W-1:0] left;
  } window_t;

  typedef struct packed {
    logic [BYTE_W-1:0] page_cmd;
    logic [BYTE_W-1:0] col_cmd;
  } cmd_bytes_t;

endpackage

/* sv/pfb_front.sv */
module pfb_front #(
  parameter int unsigned PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pfb_pkg::IN_DATA_W-1:0]    in_data_i,  // pixel_x, pixel_y, ink
  input  logic [pfb_pkg::CMD_W-1:0]        in_user_i,  // cmd
  input  logic [pfb_pkg::ROT_W-1:0]        rotation_i,
  output logic                             op_valid_o,
  input  logic                             op_ready_i,
  output pfb_pkg::op_t                     op_o
);

  localparam logic [7:0] W8   = 8'(PANEL_WIDTH);
  localparam logic [7:0] H8   = 8'(PANEL_HEIGHT);
  localparam logic [7:0] WM1  = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0] HM1  = 8'(PANEL_HEIGHT - 1);

  logic [7:0] x, y;
  logic       ink;
  logic [7:0] lw, lh;
  logic       in_range, keep, accept;
  logic [7:0] px8, py8;

  logic          op_valid_q, op_valid_d;
  pfb_pkg::op_t  op_q, op_d;

  assign x   = in_data_i[7:0];
  assign y   = in_data_i[15:8];
  assign ink = in_data_i[16];

  always_comb begin
    lw = rotation_i[0] ? H8 : W8;
    lh = rotation_i[0] ? W8 : H8;
    in_range = !x[7] && !y[7] && ({1'b0, x[6:0]} < lw) && ({1'b0, y[6:0]} < lh);
    case (rotation_i)
      pfb_pkg::ROT_90: begin
        px8 = y;
        py8 = HM1 - x;
      end
      pfb_pkg::ROT_180: begin
        px8 = WM1 - x;
        py8 = HM1 - y;
      end
      pfb_pkg::ROT_270: begin
        px8 = WM1 - y;
        py8 = x;
      end
      default: begin
        px8 = x;
        py8 = y;
      end
    endcase
  end

  always_comb begin
    case (in_user_i)
      pfb_pkg::CMD_SET:   keep = in_range;
      pfb_pkg::CMD_CLEAR: keep = 1'b1;
      pfb_pkg::CMD_PULL:  keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign in_ready_o = !op_valid_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    op_valid_d = op_valid_q;
    op_d       = op_q;
    if (accept) begin
      op_valid_d = keep;
      op_d.kind  = pfb_pkg::cmd_e'(in_user_i);
      op_d.px    = px8[pfb_pkg::COL_W-1:0];
      op_d.py    = py8[pfb_pkg::ROW_W-1:0];
      op_d.ink   = ink;
    end else if (op_ready_i) begin
      op_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= op_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = op_valid_q;
  assign op_o       = op_q;

endmodule

/* sv/pfb_fifo.sv */
module pfb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pfb_pkg::op_t  push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pfb_pkg::op_t  pop_op_o
);

  localparam int unsigned PTR_W = $clog2(pfb_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(pfb_pkg::QUEUE_DEPTH + 1);

  pfb_pkg::op_t     slot_q [pfb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(pfb_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(pfb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(pfb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

/* sv/pfb_back.sv */
module pfb_back #(
  parameter int unsigned PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_valid_i,
  output logic                         op_ready_o,
  input  pfb_pkg::op_t                 op_i,
  input  pfb_pkg::cmd_bytes_t          cmd_bytes_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pfb_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         out_is_data_o,
  output logic                         out_last_o
);

  localparam int unsigned PAGES       = (PANEL_HEIGHT + 7) / 8;
  localparam int unsigned STORE_DEPTH = PANEL_WIDTH * PAGES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COL_W       = pfb_pkg::COL_W;
  localparam int unsigned ROW_W       = pfb_pkg::ROW_W;
  localparam int unsigned PAGE_W      = pfb_pkg::PAGE_W;
  localparam int unsigned BYTE_W      = pfb_pkg::BYTE_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(PANEL_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(PANEL_HEIGHT - 1);
  localparam pfb_pkg::window_t  FULL_BOX  = '{bottom: ROW_MAX, top: '0, right: COL_MAX, left: '0};
  localparam pfb_pkg::window_t  EMPTY_BOX = '{bottom: '0, top: ROW_MAX, right: '0, left: COL_MAX};

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, acc_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [PAGE_W-1:0] acc_page;
  logic [COL_W-1:0]  acc_col;

  pfb_pkg::back_state_e  state_q, state_d;
  pfb_pkg::flush_phase_e phase_q, phase_d;
  logic [ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  pfb_pkg::window_t      box_q, box_d, win_q, win_d;
  logic [PAGE_W-1:0]     flush_page_q, flush_page_d;
  logic [COL_W-1:0]      flush_col_q, flush_col_d;

  logic [ADDR_W-1:0] set_addr_q, set_addr_d;
  logic [2:0]        set_bit_q, set_bit_d;
  logic              set_ink_q, set_ink_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              out_free, take_ok, pop;
  logic [BYTE_W-1:0] set_mask;

  assign out_free   = !out_valid_q || out_ready_i;
  assign take_ok    = (state_q == pfb_pkg::BK_IDLE) && ((op_i.kind != pfb_pkg::CMD_PULL) || out_free);
  assign op_ready_o = take_ok;
  assign pop        = op_valid_i && take_ok;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfb_pkg::BK_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) state_d = pfb_pkg::BK_IDLE;
      end
      pfb_pkg::BK_IDLE: begin
        if (pop) begin
          case (op_i.kind)
            pfb_pkg::CMD_SET:   state_d = pfb_pkg::BK_SET_WR;
            pfb_pkg::CMD_CLEAR: state_d = pfb_pkg::BK_CLEAR;
            default: begin
              if (phase_q == pfb_pkg::PH_DATA) state_d = pfb_pkg::BK_DATA_OUT;
            end
          endcase
        end
      end
      default: state_d = pfb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    if (op_i.kind == pfb_pkg::CMD_SET) begin
      acc_page = op_i.py[ROW_W-1:3];
      acc_col  = op_i.px;
    end else begin
      acc_page = flush_page_q;
      acc_col  = flush_col_q;
    end
    acc_addr = ADDR_W'(ADDR_W'(acc_page) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(acc_col));
    set_mask = BYTE_W'(1) << set_bit_q;
  end

  always_comb begin
    clr_addr_d   = (state_q == pfb_pkg::BK_CLEAR) ? clr_addr_q + 1'b1 : '0;
    phase_d      = phase_q;
    box_d        = box_q;
    win_d        = win_q;
    flush_page_d = flush_page_q;
    flush_col_d  = flush_col_q;
    set_addr_d   = set_addr_q;
    set_bit_d    = set_bit_q;
    set_ink_d    = set_ink_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = set_addr_q;
    mem_wdata    = set_ink_q ? (rd_data_q | set_mask) : (rd_data_q & ~set_mask);

    case (state_q)
      pfb_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      pfb_pkg::BK_SET_WR: begin
        mem_we = 1'b1;
      end
      pfb_pkg::BK_DATA_OUT: begin
        out_valid_d = 1'b1;
        out_byte_d  = rd_data_q;
        out_data_d  = 1'b1;
        out_last_d  = 1'b0;
      end
      default: begin
        if (pop) begin
          case (op_i.kind)
            pfb_pkg::CMD_SET: begin
              set_addr_d = acc_addr;
              set_bit_d  = op_i.py[2:0];
              set_ink_d  = op_i.ink;
              if (op_i.px < box_q.left)   box_d.left   = op_i.px;
              if (op_i.px > box_q.right)  box_d.right  = op_i.px;
              if (op_i.py < box_q.top)    box_d.top    = op_i.py;
              if (op_i.py > box_q.bottom) box_d.bottom = op_i.py;
            end
            pfb_pkg::CMD_CLEAR: begin
              box_d = FULL_BOX;
            end
            default: begin
              out_data_d = 1'b0;
              out_last_d = 1'b0;
              case (phase_q)
                pfb_pkg::PH_COL: begin
                  out_valid_d = 1'b1;
                  out_byte_d  = cmd_bytes_i.col_cmd | BYTE_W'(win_q.left);
                  flush_col_d = win_q.left;
                  phase_d     = pfb_pkg::PH_DATA;
                end
                pfb_pkg::PH_DATA: begin
                  if (flush_col_q >= win_q.right) begin
                    if (flush_page_q >= win_q.bottom[ROW_W-1:3]) begin
                      phase_d = pfb_pkg::PH_FINAL;
                    end else begin
                      flush_page_d = flush_page_q + 1'b1;
                      phase_d      = pfb_pkg::PH_PAGE;
                    end
                  end else begin
                    flush_col_d = flush_col_q + 1'b1;
                  end
                end
                pfb_pkg::PH_PAGE: begin
                  out_valid_d = 1'b1;
                  out_byte_d  = cmd_bytes_i.page_cmd | BYTE_W'(flush_page_q);
                  phase_d     = pfb_pkg::PH_COL;
                end
                pfb_pkg::PH_FINAL: begin
                  out_valid_d = 1'b1;
                  out_byte_d  = cmd_bytes_i.page_cmd;
                  out_last_d  = 1'b1;
                  phase_d     = pfb_pkg::PH_IDLE;
                end
                default: begin
                  // open a flush: latch the box, start a fresh one; an empty box closes at once
                  win_d       = box_q;
                  box_d       = EMPTY_BOX;
                  out_valid_d = 1'b1;
                  if (box_q.left > box_q.right || box_q.top > box_q.bottom) begin
                    out_byte_d = cmd_bytes_i.page_cmd;
                    out_last_d = 1'b1;
                    phase_d    = pfb_pkg::PH_IDLE;
                  end else begin
                    flush_page_d = box_q.top[ROW_W-1:3];
                    out_byte_d   = cmd_bytes_i.page_cmd | BYTE_W'(box_q.top[ROW_W-1:3]);
                    phase_d      = pfb_pkg::PH_COL;
                  end
                end
              endcase
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfb_pkg::BK_CLEAR;
      phase_q      <= pfb_pkg::PH_IDLE;
      clr_addr_q   <= '0;
      box_q        <= FULL_BOX;
      win_q        <= '0;
      flush_page_q <= '0;
      flush_col_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      clr_addr_q   <= clr_addr_d;
      box_q        <= box_d;
      win_q        <= win_d;
      flush_page_q <= flush_page_d;
      flush_col_q  <= flush_col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_addr_q <= set_addr_d;
    set_bit_q  <= set_bit_d;
    set_ink_q  <= set_ink_d;
    out_byte_q <= out_byte_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[acc_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_is_data_o = out_data_q;
  assign out_last_o    = out_last_q;

  ap_data_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfb_pkg::BK_DATA_OUT |-> !out_valid_q)
    else $error("data byte would overwrite a pending word");

  ap_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfb_pkg::BK_CLEAR |-> !op_ready_o)
    else $error("op taken during store sweep");

  ap_col_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pfb_pkg::PH_DATA |-> flush_col_q <= win_q.right)
    else $error("flush column past window");

  ap_last_is_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> !out_data_q)
    else $error("closing word flagged as data");

endmodule

/* sv/paged_framebuffer_dirty_flush_unit.sv */
// channel   dir  tdata                  tuser     tlast
// s_axis    in   pixel_x, pixel_y, ink   cmd       -
// m_axis    out  out_byte               is_data   last
// cfg       in   cfg_idx_i selects rotation / page cmd / column cmd, no handshake
//
// Words enter a one-deep decode register and a 2-entry queue at one per cycle while the
// queue has room. Back end: a set pixel reads its store byte, then writes it back in
// BK_SET_WR (read-modify-write on the one-read, one-write store); a data pull reads the
// store, then drives the byte in BK_DATA_OUT; command pulls go out from idle; clear writes
// one store byte per cycle over all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) addresses. After reset
// the same sweep runs before the first op. A stalled m_axis holds pulls only; the queue keeps taking words until full.
module paged_framebuffer_dirty_flush_unit #(
  parameter int unsigned PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] ink
  input  logic [pfb_pkg::CMD_W-1:0]         s_axis_tuser,   // [1:0] cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pfb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [7:0] out_byte
  output logic                              m_axis_tuser,   // [0] is_data
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic [pfb_pkg::ROT_W-1:0] rotation_q;
  pfb_pkg::cmd_bytes_t       cmd_bytes_q;

  logic          fr_valid, fr_ready, bk_valid, bk_ready;
  pfb_pkg::op_t  fr_op, bk_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q           <= pfb_pkg::ROTATION_RST;
      cmd_bytes_q.page_cmd <= pfb_pkg::PAGE_CMD_RST;
      cmd_bytes_q.col_cmd  <= pfb_pkg::COL_CMD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfb_pkg::REG_ROTATION: rotation_q           <= cfg_wdata_i[pfb_pkg::ROT_W-1:0];
        pfb_pkg::REG_PAGE_CMD: cmd_bytes_q.page_cmd <= cfg_wdata_i;
        pfb_pkg::REG_COL_CMD:  cmd_bytes_q.col_cmd  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pfb_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .rotation_i (rotation_q),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  pfb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_op_o     (bk_op)
  );

  pfb_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (bk_valid),
    .op_ready_o    (bk_ready),
    .op_i          (bk_op),
    .cmd_bytes_i   (cmd_bytes_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_is_data_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

endmodule
